// ----- design/kst_pkg.sv -----
// Shared types and constants for the spanning tree core.
package kst_pkg;

  localparam int unsigned VtxBits   = 6;
  localparam int unsigned CostWidth = 16;
  localparam int unsigned TotBits   = 21;
  localparam logic [TotBits-1:0] TotalMax = {TotBits{1'b1}};

  // One stored edge.
  typedef struct packed {
    logic [VtxBits-1:0]   a;
    logic [VtxBits-1:0]   b;
    logic [CostWidth-1:0] w;
  } edge_t;

  // One result item.
  typedef struct packed {
    logic [VtxBits-1:0]   from;
    logic [VtxBits-1:0]   to;
    logic [CostWidth-1:0] cost;
    logic [TotBits-1:0]   total;
    logic                 valid;
    logic                 dropped;
    logic                 last;
  } result_t;

endpackage

// ----- design/kruskal_spanning_tree_core.sv -----
// Minimum spanning tree core: edge store, stable sort and union-find sequencer.
// Load: one edge item per cycle, back to back, no result until the item marked last.
// Sort: stable insertion sort of the stored edges by cost, in place through one RAM port;
//   then a parent/rank clear sweep over node entries 0 to MAX_NODES.
// Walk: per edge, read it, find and compress both roots, join them by rank if they differ and
//   emit it (output stalls hold it), then the closing item; input stalls from last edge to it.
// Reset clears control state and sets node_count to 32; RAM contents are left as they are.
module kruskal_spanning_tree_core #(
  parameter int unsigned MAX_NODES = 32,
  parameter int unsigned MAX_EDGES = 64,
  parameter int unsigned COST_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kst_pkg::VtxBits-1:0]   cfg_node_count_i,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [kst_pkg::VtxBits-1:0]   edge_from_i,
  input  logic [kst_pkg::VtxBits-1:0]   edge_to_i,
  input  logic [kst_pkg::CostWidth-1:0] edge_cost_i,
  input  logic                          last_edge_i,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kst_pkg::VtxBits-1:0]   tree_from_o,
  output logic [kst_pkg::VtxBits-1:0]   tree_to_o,
  output logic [kst_pkg::CostWidth-1:0] tree_cost_o,
  output logic [kst_pkg::TotBits-1:0]   running_total_o,
  output logic                          edge_valid_o,
  output logic                          edges_dropped_o,
  output logic                          last_result_o
);
  import kst_pkg::*;

  localparam int unsigned EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned EC = $clog2(MAX_EDGES + 1);
  localparam int unsigned NA = $clog2(MAX_NODES + 1);
  localparam int unsigned RkBits = $clog2(NA + 1);
  localparam int unsigned EW = $bits(edge_t);
  localparam int unsigned NCNT = (NA > VtxBits) ? NA : VtxBits;
  localparam logic [CostWidth-1:0] CMask =
    (COST_BITS >= CostWidth) ? {CostWidth{1'b1}} : CostWidth'((1 << COST_BITS) - 1);

  // Sequencer states.
  localparam logic [4:0] S_LOAD  = 5'd0;
  localparam logic [4:0] S_SI    = 5'd1;   // sort: read key at i
  localparam logic [4:0] S_SK    = 5'd2;   // sort: latch key, read j-1
  localparam logic [4:0] S_SC    = 5'd3;   // sort: compare j-1, shift or place
  localparam logic [4:0] S_SP    = 5'd4;   // sort: place key at entry 0
  localparam logic [4:0] S_INIT  = 5'd5;   // union-find clear sweep
  localparam logic [4:0] S_ER    = 5'd6;   // read edge i
  localparam logic [4:0] S_EL    = 5'd7;   // latch edge
  localparam logic [4:0] S_FR    = 5'd8;   // find: read parent of r
  localparam logic [4:0] S_FW    = 5'd9;   // find: compare
  localparam logic [4:0] S_CW    = 5'd10;  // compress: step
  localparam logic [4:0] S_JA    = 5'd11;  // join: rank a
  localparam logic [4:0] S_JB    = 5'd12;  // join: rank b and decide
  localparam logic [4:0] S_OUT   = 5'd13;  // emit result
  localparam logic [4:0] S_FIN   = 5'd14;  // emit closing item

  logic [4:0]         st_q, st_d;
  logic [VtxBits-1:0] nc_q;
  logic [EC-1:0]      fill_q, fill_d;
  logic               ovf_q, ovf_d;
  logic [EC-1:0]      i_q, i_d, j_q, j_d;
  edge_t              key_q, key_d, cur_q, cur_d;
  logic [NA-1:0]      v_q, v_d, r_q, r_d, ra_q, ra_d;
  logic               side_q, side_d;
  logic [RkBits-1:0]  rka_q, rka_d;
  logic [TotBits-1:0] sum_q, sum_d;
  logic [TotBits:0]   sum_ext;
  logic               ov_q;
  result_t            res_q, res_d;
  logic               rv_d;

  // Edge RAM ports.
  logic          e_we;
  logic [EA-1:0] e_wa, e_ra;
  edge_t         e_wd, e_rd;
  logic [EW-1:0] e_rbits;
  // Parent and rank RAM ports.
  logic              p_we, k_we;
  logic [NA-1:0]     p_wa, p_ra, k_wa, k_ra;
  logic [NA-1:0]     p_wd, p_rd;
  logic [RkBits-1:0] k_wd, k_rd;

  kst_ram #(.Width(EW), .Depth(MAX_EDGES)) u_edges (
    .clk_i, .we_i(e_we), .waddr_i(e_wa), .wdata_i(e_wd), .raddr_i(e_ra), .rdata_o(e_rbits)
  );
  assign e_rd = edge_t'(e_rbits);
  kst_ram #(.Width(NA), .Depth(MAX_NODES + 1)) u_parent (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd), .raddr_i(p_ra), .rdata_o(p_rd)
  );
  kst_ram #(.Width(RkBits), .Depth(MAX_NODES + 1)) u_rank (
    .clk_i, .we_i(k_we), .waddr_i(k_wa), .wdata_i(k_wd), .raddr_i(k_ra), .rdata_o(k_rd)
  );

  logic [NCNT:0] nc_eff;
  logic          vtx_ok, in_acc, out_free;
  assign nc_eff = ({1'b0, NCNT'(nc_q)} > (NCNT+1)'(MAX_NODES)) ? (NCNT+1)'(MAX_NODES)
                                                               : {1'b0, NCNT'(nc_q)};
  assign vtx_ok = (edge_from_i != '0) && (edge_to_i != '0) &&
                  ((NCNT+1)'(edge_from_i) <= nc_eff) && ((NCNT+1)'(edge_to_i) <= nc_eff);
  assign in_stall = (st_q != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !ov_q || !out_stall;
  assign cfg_ready = (st_q == S_LOAD);
  assign sum_ext  = {1'b0, sum_q} + (TotBits+1)'(cur_q.w);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q <= VtxBits'(32);
    end else if (cfg_valid && cfg_ready) begin
      nc_q <= cfg_node_count_i;
    end
  end

  // Main sequencer.
  always_comb begin
    st_d = st_q; fill_d = fill_q; ovf_d = ovf_q; i_d = i_q; j_d = j_q;
    key_d = key_q; cur_d = cur_q; v_d = v_q; r_d = r_q; ra_d = ra_q;
    side_d = side_q; rka_d = rka_q; sum_d = sum_q; res_d = res_q; rv_d = 1'b0;
    e_we = 1'b0; e_wa = EA'(fill_q); e_wd = '0; e_ra = EA'(i_q);
    p_we = 1'b0; p_wa = v_q; p_wd = '0; p_ra = r_q;
    k_we = 1'b0; k_wa = v_q; k_wd = '0; k_ra = ra_q;
    unique case (st_q)
      S_LOAD: begin
        if (in_acc) begin
          if (vtx_ok) begin
            if (fill_q < EC'(MAX_EDGES)) begin
              e_we = 1'b1;
              e_wd = '{a: edge_from_i, b: edge_to_i, w: edge_cost_i & CMask};
              fill_d = fill_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (last_edge_i) begin
            i_d = EC'(1);
            st_d = S_SI;
          end
        end
      end
      S_SI: begin
        if (i_q >= fill_q) begin
          v_d = '0; st_d = S_INIT;
        end else begin
          e_ra = EA'(i_q); j_d = i_q; st_d = S_SK;
        end
      end
      S_SK: begin
        key_d = e_rd; e_ra = EA'(j_q - 1'b1); st_d = S_SC;
      end
      S_SC: begin
        // e_rd holds entry j-1; shift it up while it costs more than the key
        if (e_rd.w > key_q.w) begin
          e_we = 1'b1; e_wa = EA'(j_q); e_wd = e_rd;
          j_d = j_q - 1'b1;
          if (j_q == EC'(1)) begin
            st_d = S_SP;
          end else begin
            e_ra = EA'(j_q - EC'(2));
          end
        end else begin
          e_we = 1'b1; e_wa = EA'(j_q); e_wd = key_q;
          i_d = i_q + 1'b1; st_d = S_SI;
        end
      end
      S_SP: begin
        e_we = 1'b1; e_wa = '0; e_wd = key_q;
        i_d = i_q + 1'b1; st_d = S_SI;
      end
      S_INIT: begin
        p_we = 1'b1; p_wa = v_q; p_wd = v_q;
        k_we = 1'b1; k_wa = v_q; k_wd = '0;
        v_d = v_q + 1'b1;
        if (v_q == NA'(MAX_NODES)) begin
          i_d = '0; sum_d = '0; st_d = S_ER;
        end
      end
      S_ER: begin
        if (i_q >= fill_q) begin
          st_d = S_FIN;
        end else begin
          e_ra = EA'(i_q); st_d = S_EL; side_d = 1'b0;
        end
      end
      S_EL: begin
        cur_d = e_rd; side_d = 1'b0;
        r_d = NA'(e_rd.a); v_d = NA'(e_rd.a); st_d = S_FR;
      end
      S_FR: begin
        p_ra = r_q; st_d = S_FW;
      end
      S_FW: begin
        if (p_rd != r_q) begin
          r_d = p_rd; p_ra = p_rd; st_d = S_FW;
        end else begin
          p_ra = v_q; st_d = S_CW;
        end
      end
      S_CW: begin
        // p_rd is parent of v; point v at the root and follow the old parent
        if (p_rd != r_q) begin
          p_we = 1'b1; p_wa = v_q; p_wd = r_q;
          v_d = p_rd; p_ra = p_rd;
        end else if (!side_q) begin
          ra_d = r_q; side_d = 1'b1;
          r_d = NA'(cur_q.b); v_d = NA'(cur_q.b); st_d = S_FR;
        end else begin
          side_d = 1'b0;
          if (ra_q == r_q) begin
            i_d = i_q + 1'b1; st_d = S_ER;
          end else begin
            k_ra = ra_q; st_d = S_JA;
          end
        end
      end
      S_JA: begin
        rka_d = k_rd; k_ra = r_q; st_d = S_JB;
      end
      S_JB: begin
        // k_rd = rank of rb (r_q); ra_q has rka_q
        if (rka_q < k_rd) begin
          p_we = 1'b1; p_wa = ra_q; p_wd = r_q;
        end else begin
          p_we = 1'b1; p_wa = r_q; p_wd = ra_q;
          if (rka_q == k_rd) begin
            k_we = 1'b1; k_wa = ra_q; k_wd = rka_q + 1'b1;
          end
        end
        sum_d = sum_ext[TotBits] ? TotalMax : sum_ext[TotBits-1:0];
        st_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          rv_d = 1'b1;
          res_d = '{from: cur_q.a, to: cur_q.b, cost: cur_q.w, total: sum_q,
                    valid: 1'b1, dropped: ovf_q, last: 1'b0};
          i_d = i_q + 1'b1; st_d = S_ER;
        end
      end
      S_FIN: begin
        if (out_free) begin
          rv_d = 1'b1;
          res_d = '{from: '0, to: '0, cost: '0, total: sum_q,
                    valid: 1'b0, dropped: ovf_q, last: 1'b1};
          fill_d = '0; ovf_d = 1'b0; sum_d = '0; st_d = S_LOAD;
        end
      end
      default: st_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD; fill_q <= '0; ovf_q <= 1'b0; sum_q <= '0; ov_q <= 1'b0;
      side_q <= 1'b0;
    end else begin
      st_q <= st_d; fill_q <= fill_d; ovf_q <= ovf_d; sum_q <= sum_d;
      side_q <= side_d;
      if (rv_d) ov_q <= 1'b1;
      else if (!out_stall) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; key_q <= key_d; cur_q <= cur_d; v_q <= v_d;
    r_q <= r_d; ra_q <= ra_d; rka_q <= rka_d; res_q <= res_d;
  end

  assign out_valid       = ov_q;
  assign tree_from_o     = res_q.from;
  assign tree_to_o       = res_q.to;
  assign tree_cost_o     = res_q.cost;
  assign running_total_o = res_q.total;
  assign edge_valid_o    = res_q.valid;
  assign edges_dropped_o = res_q.dropped;
  assign last_result_o   = res_q.last;

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= EC'(MAX_EDGES)) else $error("fill count beyond store");
  a_nocfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != S_LOAD |-> !cfg_ready) else $error("cfg taken while busy");
  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_FIN && out_free) |=> (st_q == S_LOAD && fill_q == '0))
    else $error("store not cleared after graph");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_stall) |=> (out_valid && $stable(res_q)))
    else $error("result changed while stalled");

endmodule

// ----- design/kst_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module kst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- verif/kruskal_spanning_tree_core_checker.sv -----
// Checker for the spanning tree core: tracks edge items, predicts tree results, compares.
`timescale 1ns / 1ps
module kruskal_spanning_tree_core_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [kst_pkg::VtxBits-1:0]   cfg_node_count_i,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [kst_pkg::VtxBits-1:0]   edge_from_i,
  input  logic [kst_pkg::VtxBits-1:0]   edge_to_i,
  input  logic [kst_pkg::CostWidth-1:0] edge_cost_i,
  input  logic                          last_edge_i,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [kst_pkg::VtxBits-1:0]   tree_from_o,
  input  logic [kst_pkg::VtxBits-1:0]   tree_to_o,
  input  logic [kst_pkg::CostWidth-1:0] tree_cost_o,
  input  logic [kst_pkg::TotBits-1:0]   running_total_o,
  input  logic                          edge_valid_o,
  input  logic                          edges_dropped_o,
  input  logic                          last_result_o,
  output int                            fail_count,
  output int                            pending_count
);
  import kst_pkg::*;

  localparam int unsigned MaxNodes = 32;
  localparam int unsigned MaxEdges = 64;

  logic [VtxBits-1:0] node_limit;
  edge_t              graph_edges[$];
  logic               dropped_flag;
  logic [VtxBits-1:0] parent[MaxNodes+1];
  logic [2:0]         set_rank[MaxNodes+1];
  result_t            tree_queue[$];

  function automatic logic [VtxBits-1:0] find_root(logic [VtxBits-1:0] v);
    logic [VtxBits-1:0] r;
    logic [VtxBits-1:0] nxt;
    r = v;
    while (parent[r] != r) r = parent[r];
    while (parent[v] != r) begin
      nxt = parent[v];
      parent[v] = r;
      v = nxt;
    end
    return r;
  endfunction

  // Sort stably, walk union-find, queue chosen edges and the closing total
  task automatic build_tree();
    edge_t              key;
    edge_t              srt[$];
    int                 j;
    logic [VtxBits-1:0] ra, rb, t;
    logic [TotBits:0]   sum;
    result_t            r;
    srt = graph_edges;
    for (int i = 1; i < srt.size(); i++) begin
      key = srt[i];
      j = i;
      while (j > 0 && srt[j-1].w > key.w) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = key;
    end
    for (int v = 0; v <= MaxNodes; v++) begin
      parent[v] = v[VtxBits-1:0];
      set_rank[v] = '0;
    end
    sum = '0;
    foreach (srt[i]) begin
      ra = find_root(srt[i].a);
      rb = find_root(srt[i].b);
      if (ra != rb) begin
        if (set_rank[ra] < set_rank[rb]) begin
          t = ra; ra = rb; rb = t;
        end
        parent[rb] = ra;
        if (set_rank[ra] == set_rank[rb]) set_rank[ra]++;
        sum += srt[i].w;
        if (sum > TotalMax) sum = TotalMax;
        r = '{from: srt[i].a, to: srt[i].b, cost: srt[i].w, total: sum[TotBits-1:0],
              valid: 1'b1, dropped: dropped_flag, last: 1'b0};
        tree_queue.insert(tree_queue.size(), r);
      end
    end
    r = '{from: '0, to: '0, cost: '0, total: sum[TotBits-1:0], valid: 1'b0,
          dropped: dropped_flag, last: 1'b1};
    tree_queue.insert(tree_queue.size(), r);
    graph_edges.delete();
    dropped_flag = 1'b0;
  endtask

  task automatic report_mismatch(string what, result_t exp_r, result_t act_r);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch (%s) at %0t: expected %p actual %p", what, $realtime, exp_r, act_r);
  endtask

  // Watch all channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    logic [VtxBits-1:0] nc;
    edge_t   e;
    result_t act_r;
    result_t exp_r;
    if (!rst_ni) begin
      node_limit    <= 6'd32;
      fail_count    = 0;
      pending_count = 0;
      dropped_flag  = 1'b0;
      graph_edges.delete();
      tree_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) node_limit <= cfg_node_count_i;
      if (in_valid && !in_stall) begin
        nc = (node_limit > MaxNodes) ? 6'(MaxNodes) : node_limit;
        if (edge_from_i >= 1 && edge_from_i <= nc && edge_to_i >= 1 && edge_to_i <= nc) begin
          if (graph_edges.size() < MaxEdges) begin
            e = '{a: edge_from_i, b: edge_to_i, w: edge_cost_i};
            graph_edges.insert(graph_edges.size(), e);
          end else begin
            dropped_flag = 1'b1;
          end
        end
        if (last_edge_i) build_tree();
      end
      if (out_valid && !out_stall) begin
        act_r = '{from: tree_from_o, to: tree_to_o, cost: tree_cost_o,
                  total: running_total_o, valid: edge_valid_o,
                  dropped: edges_dropped_o, last: last_result_o};
        if (tree_queue.size() == 0) begin
          report_mismatch("unexpected", '0, act_r);
        end else begin
          exp_r = tree_queue.pop_front();
          if (act_r !== exp_r) report_mismatch("field", exp_r, act_r);
        end
      end
      pending_count = tree_queue.size();
    end
  end

endmodule

// ----- verif/kruskal_spanning_tree_core_tb.sv -----
// Testbench top for the spanning tree core: stimulus, idling, hold-off and verdict.
`timescale 1ns / 1ps
module kruskal_spanning_tree_core_tb;
  import kst_pkg::*;

  localparam int unsigned CycleLimit = 3000000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [VtxBits-1:0]   cfg_node_count_i = 6'd32;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [VtxBits-1:0]   edge_from_i = '0;
  logic [VtxBits-1:0]   edge_to_i = '0;
  logic [CostWidth-1:0] edge_cost_i = '0;
  logic                 last_edge_i = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [VtxBits-1:0]   tree_from_o;
  logic [VtxBits-1:0]   tree_to_o;
  logic [CostWidth-1:0] tree_cost_o;
  logic [TotBits-1:0]   running_total_o;
  logic                 edge_valid_o;
  logic                 edges_dropped_o;
  logic                 last_result_o;
  int                   fail_count;
  int                   pending_count;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   hold_off = 0;
  int unsigned          cycle_count = 0;
  logic [VtxBits-1:0]   cur_nodes = 6'd32;

  always #10 clk_i = ~clk_i;

  kruskal_spanning_tree_core u_top (.*);

  kruskal_spanning_tree_core_checker u_checker (.*);

  // Stall the result side at random, or hard during a hold-off
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Abort on a runaway run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("kruskal_spanning_tree_core regression: fail");
      $finish;
    end
  end

  // Offer one edge item and hold it until accepted; valid stays up for the next item
  task automatic send_edge(logic [VtxBits-1:0] a, logic [VtxBits-1:0] b,
                           logic [CostWidth-1:0] w, logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    edge_from_i <= a;
    edge_to_i <= b;
    edge_cost_i <= w;
    last_edge_i <= fin;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // Write node_count while the core is idle
  task automatic set_nodes(logic [VtxBits-1:0] n);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_node_count_i <= n;
    cur_nodes <= n;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [VtxBits-1:0] pick_vertex();
    logic [VtxBits-1:0] lim;
    lim = (cur_nodes == 0) ? 6'd1 : cur_nodes;
    if ($urandom_range(19) == 0) return 6'($urandom_range(63));
    return 6'($urandom_range(lim, 1));
  endfunction

  // Send one random graph of n_edges items, marking the final one last
  task automatic random_graph(int n_edges);
    for (int i = 0; i < n_edges; i++)
      send_edge(pick_vertex(), pick_vertex(),
                ($urandom_range(3) == 0) ? 16'($urandom_range(7)) : 16'($urandom),
                i == n_edges - 1);
  endtask

  task automatic random_phase(int items);
    int sent;
    int n;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(15) == 0) ? $urandom_range(70, 66) : $urandom_range(12, 1);
      random_graph(n);
      sent += n;
    end
  endtask

  initial begin
    send_idle_pct = 8;
    recv_idle_pct = 73;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty graph, extremes, self loop, invalid vertices, ties
    send_edge(6'd0, 6'd0, 16'd0, 1'b1);
    send_edge(6'd1, 6'd32, 16'hFFFF, 1'b0);
    send_edge(6'd5, 6'd5, 16'd3, 1'b0);
    send_edge(6'd33, 6'd2, 16'd1, 1'b0);
    send_edge(6'd63, 6'd0, 16'd1, 1'b0);
    send_edge(6'd2, 6'd32, 16'd7, 1'b0);
    send_edge(6'd1, 6'd2, 16'd7, 1'b0);
    send_edge(6'd32, 6'd31, 16'hAAAA, 1'b0);
    send_edge(6'd31, 6'd1, 16'h5555, 1'b1);
    set_nodes(6'd0);
    send_edge(6'd1, 6'd1, 16'd9, 1'b1);
    set_nodes(6'd63);
    send_edge(6'd32, 6'd1, 16'd2, 1'b0);
    send_edge(6'd33, 6'd1, 16'd2, 1'b1);
    set_nodes(6'd1);
    send_edge(6'd1, 6'd1, 16'd4, 1'b0);
    send_edge(6'd2, 6'd1, 16'd4, 1'b1);
    set_nodes(6'd32);

    // Random: receiver mostly stalled
    random_phase(70);
    set_nodes(6'd2);
    random_phase(10);
    set_nodes(6'd32);

    // Random: sender mostly idle, then a long receiver hold-off
    send_idle_pct = 73;
    recv_idle_pct = 8;
    random_phase(45);
    wait_drained();
    send_idle_pct = 0;
    hold_off = 3000;
    random_graph(3);
    random_graph(30);
    random_graph(20);

    // Random: no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_nodes(6'd17);
    random_phase(25);
    set_nodes(6'd32);
    random_phase(30);

    wait_drained();
    repeat (200) @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("kruskal_spanning_tree_core regression: pass");
    end else begin
      $display("kruskal_spanning_tree_core regression: fail");
    end
    $finish;
  end

endmodule
